@@ rtl/salc_pkg.sv @@
`default_nettype none
package salc_pkg;
  localparam int LINE_SHIFT = 5;
  localparam int LINE_BYTES = 32;
  localparam int STAMP_W = 32;
  localparam int CNT_W = 32;

  localparam logic [1:0] REG_WAYS = 2'd0;
  localparam logic [1:0] REG_STALLOC = 2'd1;
  localparam logic [1:0] REG_PFMODE = 2'd2;

  localparam logic [1:0] PF_NONE = 2'd0;
  localparam logic [1:0] PF_ALWAYS = 2'd1;
  localparam logic [1:0] PF_MISS = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;    // begin a lookup of in_addr, or of the next line
    logic use_pf;   // lookup address is the next line
    logic alloc;    // fill on miss
    logic step;     // scan one way
    logic finish;   // perform the fill or refresh
  } salc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_done;
    logic hit;
  } salc_sts_t;
endpackage
`default_nettype wire

@@ rtl/salc_ctrl.sv @@
`default_nettype none
module salc_ctrl
  import salc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_fire,
  input  wire logic        is_store,
  input  wire logic        store_allocate,
  input  wire logic [1:0]  prefetch_mode,
  input  wire logic        out_free,
  input  salc_sts_t        sts,
  output salc_cmd_t        cmd,
  output logic             busy,
  output logic             res_load,
  output logic             res_hit,
  output logic             res_pf,
  output logic             res_pf_hit
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DSCAN = 3'd1;
  localparam logic [2:0] S_DFIN = 3'd2;
  localparam logic [2:0] S_PSCAN = 3'd3;
  localparam logic [2:0] S_PFIN = 3'd4;
  localparam logic [2:0] S_OUT = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       store_r, hit_r, hit_nxt, pf_r, pf_nxt, pfh_r, pfh_nxt;
  logic       do_pf;

  assign busy = (state_r != S_IDLE);
  assign do_pf = (prefetch_mode == PF_ALWAYS) || (prefetch_mode == PF_MISS && !hit_r);

  always_comb begin
    state_nxt = state_r;
    hit_nxt = hit_r;
    pf_nxt = pf_r;
    pfh_nxt = pfh_r;
    cmd = '0;
    res_load = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd.start = 1'b1;
          pf_nxt = 1'b0;
          pfh_nxt = 1'b0;
          state_nxt = S_DSCAN;
        end
      end
      S_DSCAN: begin
        cmd.step = 1'b1;
        if (sts.scan_done) state_nxt = S_DFIN;
      end
      S_DFIN: begin
        cmd.finish = 1'b1;
        cmd.alloc = !store_r || store_allocate;
        hit_nxt = sts.hit;
        state_nxt = S_PSCAN;
      end
      S_PSCAN: begin
        if (!pf_r && do_pf) begin
          cmd.start = 1'b1;
          cmd.use_pf = 1'b1;
          pf_nxt = 1'b1;
        end else if (pf_r) begin
          cmd.step = 1'b1;
          if (sts.scan_done) state_nxt = S_PFIN;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_PFIN: begin
        cmd.finish = 1'b1;
        cmd.alloc = 1'b1;
        pfh_nxt = sts.hit;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          res_load = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    if (in_fire) store_r <= is_store;
    hit_r <= hit_nxt;
    pf_r <= pf_nxt;
    pfh_r <= pfh_nxt;
  end

  assign res_hit = hit_r;
  assign res_pf = pf_r;
  assign res_pf_hit = pfh_r;

  property p_fin_after_scan;
    @(posedge clk) disable iff (!rst_n) (state_r == S_DFIN) |-> $past(state_r == S_DSCAN);
  endproperty
  a_fin_after_scan: assert property (p_fin_after_scan) else $error("fill without scan");
  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |=> (state_r == S_IDLE)) else $error("result not followed by idle");
  a_no_fire_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (busy && state_r != S_DSCAN && state_r != S_PSCAN) |-> !cmd.step)
    else $error("scan step outside scan");
endmodule
`default_nettype wire

@@ rtl/salc_dp.sv @@
`default_nettype none
module salc_dp
  import salc_pkg::*;
#(
  parameter int LINES_LOG = 9,
  parameter int MAX_WAYS = 16,
  parameter int ADDR_BITS = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_fire,
  input  wire logic [ADDR_BITS-1:0] in_addr,
  input  wire logic [2:0]           way_count_log,
  input  wire logic [STAMP_W-1:0]   stamp,
  input  salc_cmd_t                 cmd,
  output salc_sts_t                 sts,
  output logic                      clearing
);
  localparam int LINES = 1 << LINES_LOG;
  localparam int WL_LIM0 = $clog2(MAX_WAYS + 1) - 1;
  localparam int WL_LIM = (WL_LIM0 < LINES_LOG) ? WL_LIM0 : LINES_LOG;
  localparam int TAG_W = ADDR_BITS - LINE_SHIFT;
  localparam int WC_W = $clog2(MAX_WAYS + 1) + 1;

  // Each tag entry carries its valid bit in the top position.
  logic [TAG_W:0]     tag_mem [LINES];
  logic [STAMP_W-1:0] stamp_mem [LINES];

  logic [ADDR_BITS-1:0] addr_r, look_addr;
  logic [2:0]           wl;
  logic [LINES_LOG-1:0] base_r, idx, idx_d_r, victim_r, hit_idx_r, clr_idx_r;
  logic [WC_W-1:0]      w_r, ways;
  logic [TAG_W-1:0]     tag_r;
  logic [TAG_W:0]       tag_rd;
  logic [STAMP_W-1:0]   stamp_rd, best_r;
  logic                 rd_v_r, hit_r, empty_r, vic_set_r, clr_act_r;
  logic [LINES_LOG:0]   sb;
  logic [ADDR_BITS-1:0] line_no;

  assign wl = (32'(way_count_log) < WL_LIM) ? way_count_log : 3'(WL_LIM);
  assign ways = WC_W'(1) << wl;
  assign sb = (LINES_LOG + 1)'(LINES_LOG) - (LINES_LOG + 1)'(wl);
  assign look_addr = cmd.use_pf ? addr_r + ADDR_BITS'(LINE_BYTES) : in_addr;
  assign line_no = look_addr >> LINE_SHIFT;
  assign idx = base_r + LINES_LOG'(w_r);

  // Sequential scan: one way read per cycle, compared in the following cycle.
  always_ff @(posedge clk) begin
    tag_rd <= tag_mem[idx];
    stamp_rd <= stamp_mem[idx];
    if (in_fire) addr_r <= in_addr;
    if (cmd.start) begin
      base_r <= LINES_LOG'((line_no & ((ADDR_BITS'(1) << sb) - 1'b1)) << wl);
      tag_r <= TAG_W'(line_no >> sb);
      w_r <= '0;
      rd_v_r <= 1'b0;
      hit_r <= 1'b0;
      empty_r <= 1'b0;
      vic_set_r <= 1'b0;
    end else if (cmd.step) begin
      rd_v_r <= (w_r < ways);
      idx_d_r <= idx;
      if (w_r < ways) w_r <= w_r + 1'b1;
      if (rd_v_r && !hit_r) begin
        if (tag_rd[TAG_W] && tag_rd[TAG_W-1:0] == tag_r) begin
          hit_r <= 1'b1;
          hit_idx_r <= idx_d_r;
        end else if (!tag_rd[TAG_W]) begin
          if (!empty_r) begin
            empty_r <= 1'b1;
            victim_r <= idx_d_r;
          end
        end else if (!empty_r && (!vic_set_r || stamp_rd < best_r)) begin
          vic_set_r <= 1'b1;
          best_r <= stamp_rd;
          victim_r <= idx_d_r;
        end
      end
    end
  end

  assign sts.scan_done = cmd.step && !rd_v_r && (w_r == ways);
  assign sts.hit = hit_r;
  assign clearing = clr_act_r;

  // After reset every entry is written invalid, one per cycle.
  always_ff @(posedge clk) begin
    if (clr_act_r) begin
      tag_mem[clr_idx_r] <= '0;
    end else if (cmd.finish) begin
      if (hit_r) begin
        stamp_mem[hit_idx_r] <= stamp;
      end else if (cmd.alloc) begin
        stamp_mem[victim_r] <= stamp;
        tag_mem[victim_r] <= {1'b1, tag_r};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_act_r <= 1'b1;
      clr_idx_r <= '0;
    end else if (clr_act_r) begin
      clr_idx_r <= clr_idx_r + 1'b1;
      if (clr_idx_r == '1) clr_act_r <= 1'b0;
    end
  end
endmodule
`default_nettype wire

@@ rtl/set_assoc_lru_cache_tags.sv @@
`default_nettype none
// Tag-only set-associative cache with 32-byte lines, LRU replacement and an
// optional next-line prefetch. Each access beat produces one result beat.
// After reset a clearing pass marks every line invalid, one line per cycle,
// while in_tready stays low. An access scans the ways of its set one per cycle
// through a single registered memory read port; the demand lookup is accepted,
// scanned and ends with the fill or refresh. A decision step then starts the
// prefetch when one runs, and the prefetch lookup scans and then fills or
// refreshes in the same way. A last step hands the result to the output
// register, waiting while the previous result beat still waits on out_tready,
// and the next beat can be accepted in the cycle after that.
module set_assoc_lru_cache_tags
  import salc_pkg::*;
#(
  parameter int LINES_LOG = 9,
  parameter int MAX_WAYS = 16,
  parameter int ADDR_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [ADDR_BITS-1:0] in_tdata,  // address
  input  wire logic        in_tuser,           // is_store
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,          // hit, prefetch_issued, prefetch_hit, hit_count
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  logic [2:0] wcl_r;
  logic       sta_r;
  logic [1:0] pfm_r;
  logic       busy, in_fire, res_load, rh, rp, rph, cfg_wr, clearing;
  logic [CNT_W-1:0] hits_r;
  logic [CNT_W-1:0] stamp_ctr_r;
  salc_cmd_t cmd;
  salc_sts_t sts;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wcl_r <= '0;
      sta_r <= 1'b1;
      pfm_r <= PF_NONE;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        REG_WAYS: wcl_r <= cfg_pwdata[2:0];
        REG_STALLOC: sta_r <= cfg_pwdata[0];
        REG_PFMODE: pfm_r <= cfg_pwdata[1:0];
        default: ;
      endcase
    end
  end
  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_WAYS: cfg_prdata = {29'd0, wcl_r};
      REG_STALLOC: cfg_prdata = {31'd0, sta_r};
      REG_PFMODE: cfg_prdata = {30'd0, pfm_r};
      default: cfg_prdata = '0;
    endcase
  end

  assign in_tready = !busy && !clearing;
  assign in_fire = in_tvalid && in_tready;

  salc_ctrl u_ctrl (
    .clk, .rst_n, .in_fire, .is_store(in_tuser), .store_allocate(sta_r),
    .prefetch_mode(pfm_r), .out_free(!out_tvalid || out_tready), .sts, .cmd, .busy,
    .res_load, .res_hit(rh), .res_pf(rp), .res_pf_hit(rph)
  );

  salc_dp #(.LINES_LOG(LINES_LOG), .MAX_WAYS(MAX_WAYS), .ADDR_BITS(ADDR_BITS)) u_dp (
    .clk, .rst_n, .in_fire, .in_addr(in_tdata), .way_count_log(wcl_r),
    .stamp(stamp_ctr_r), .cmd, .sts, .clearing
  );

  // The stamp counter advances once the access is complete, so both lookups
  // of one access use the same stamp.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid <= 1'b0;
      hits_r <= '0;
      stamp_ctr_r <= '0;
    end else begin
      if (out_tvalid && out_tready) out_tvalid <= 1'b0;
      if (res_load) begin
        out_tvalid <= 1'b1;
        out_tdata <= {5'd0, (rh && hits_r != '1) ? hits_r + 1'b1 : hits_r, rph, rp, rh};
        if (rh && hits_r != '1) hits_r <= hits_r + 1'b1;
        if (stamp_ctr_r != '1) stamp_ctr_r <= stamp_ctr_r + 1'b1;
      end
    end
  end

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |-> (!out_tvalid || out_tready)) else $error("result overwrites pending beat");
  a_hits_mono: assert property (@(posedge clk) disable iff (!rst_n)
    hits_r >= $past(hits_r)) else $error("hit count went down");
  a_busy_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> busy) else $error("accepted beat not worked");
endmodule
`default_nettype wire

@@ test/tb.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Checks the tag-only set-associative cache with LRU replacement and
// next-line prefetch. The testbench keeps its own copy of the tag, valid
// and stamp stores and updates them for every accepted access beat, so each
// result beat is compared field by field against an expectation in order.
module tb;
  import salc_pkg::*;

  localparam int NLINES = 512;
  localparam int WAYS_LOG_MAX = 4;
  localparam int LAT = 80;
  localparam int WDOG_LIMIT = 4000;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [31:0] in_tdata;    // address
  logic in_tuser;           // is_store
  logic out_tvalid;
  logic out_tready;
  logic [39:0] out_tdata;   // hit, prefetch_issued, prefetch_hit, hit_count
  logic cfg_psel;
  logic cfg_penable;
  logic cfg_pwrite;
  logic [3:0] cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  set_assoc_lru_cache_tags dut (.*);

  typedef struct packed {
    logic [31:0] hit_count;
    logic pf_hit;
    logic pf_issued;
    logic hit;
  } lookup_result_t;

  // The model of the cache contents.
  logic [31:0] line_tag [NLINES];
  logic line_ok [NLINES];
  logic [31:0] line_stamp [NLINES];
  logic [31:0] access_stamp;
  logic [31:0] demand_hits;
  logic [2:0] ways_log_reg;
  logic store_alloc_reg;
  logic [1:0] pf_mode_reg;

  lookup_result_t expected_results[$];
  int errors;
  int accesses_sent;
  int results_seen;
  int idle_cycles;

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // Look up one line in the model, refreshing on hit or filling on miss when alloc is set.
  function automatic logic model_touch(input logic [31:0] a, input logic alloc,
                                       input logic [31:0] stamp);
    int wl, sb, nways, base, victim, idx;
    logic [31:0] set_idx, tag, oldest;
    logic empty_found;
    wl = (ways_log_reg > WAYS_LOG_MAX) ? WAYS_LOG_MAX : ways_log_reg;
    sb = 9 - wl;
    nways = 1 << wl;
    set_idx = (a >> LINE_SHIFT) & ((32'd1 << sb) - 1);
    tag = a >> (LINE_SHIFT + sb);
    base = set_idx << wl;
    victim = 0;
    empty_found = 0;
    for (int w = 0; w < nways; w++) begin
      idx = (base + w) % NLINES;
      if (line_ok[idx] && line_tag[idx] == tag) begin
        line_stamp[idx] = stamp;
        return 1'b1;
      end
    end
    if (!alloc) return 1'b0;
    for (int w = 0; w < nways; w++) begin
      idx = (base + w) % NLINES;
      if (!line_ok[idx] && !empty_found) begin
        victim = w;
        empty_found = 1;
      end
    end
    if (!empty_found) begin
      oldest = line_stamp[base % NLINES];
      for (int w = 1; w < nways; w++) begin
        idx = (base + w) % NLINES;
        if (line_stamp[idx] < oldest) begin
          oldest = line_stamp[idx];
          victim = w;
        end
      end
    end
    idx = (base + victim) % NLINES;
    line_tag[idx] = tag;
    line_ok[idx] = 1'b1;
    line_stamp[idx] = stamp;
    return 1'b0;
  endfunction

  function automatic lookup_result_t predict_access(input logic [31:0] a,
                                                    input logic st);
    lookup_result_t r;
    r = '0;
    r.hit = model_touch(a, !st || store_alloc_reg, access_stamp);
    if (r.hit && demand_hits != 32'hFFFF_FFFF) demand_hits++;
    if (pf_mode_reg == PF_ALWAYS || (pf_mode_reg == PF_MISS && !r.hit)) begin
      r.pf_issued = 1'b1;
      r.pf_hit = model_touch(a + LINE_BYTES, 1'b1, access_stamp);
    end
    if (access_stamp != 32'hFFFF_FFFF) access_stamp++;
    r.hit_count = demand_hits;
    return r;
  endfunction

  // Sends one access beat; the sender works in bursts with random gaps.
  // Valid stays high between beats of a burst and drops only for a gap.
  int burst_left;
  task automatic send_access(input logic [31:0] a, input logic st);
    lookup_result_t exp_r;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      if ($urandom_range(0, 2) != 0) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata <= a;
    in_tuser <= st;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    exp_r = predict_access(a, st);
    expected_results = {expected_results, exp_r};
    accesses_sent++;
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (LAT) @(posedge clk);
  endtask

  // Register write with a setup phase and an enable phase, done only while the cache is idle.
  task automatic write_reg(input logic [1:0] index, input logic [31:0] value);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= {index, 2'b00};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    case (index)
      REG_WAYS: ways_log_reg = value[2:0];
      REG_STALLOC: store_alloc_reg = value[0];
      default: pf_mode_reg = value[1:0];
    endcase
  endtask

  task automatic configure(input logic [2:0] wl, input logic sa, input logic [1:0] pm);
    wait_drained();
    write_reg(REG_WAYS, 32'(wl));
    write_reg(REG_STALLOC, 32'(sa));
    write_reg(REG_PFMODE, 32'(pm));
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  // Directed accesses: address extremes, conflicts, wrap of the next line.
  task automatic test_directed();
    configure(3'd1, 1'b1, PF_NONE);
    send_access(32'h0000_0000, 1'b0);
    send_access(32'h0000_0000, 1'b0);
    send_access(32'hFFFF_FFFF, 1'b0);
    send_access(32'hFFFF_FFE0, 1'b1);
    send_access(32'h0000_4000, 1'b0);
    send_access(32'h0000_8000, 1'b0);
    send_access(32'h0000_0000, 1'b0);
    configure(3'd2, 1'b0, PF_ALWAYS);
    send_access(32'h1234_5600, 1'b1);
    send_access(32'h1234_5600, 1'b0);
    send_access(32'hFFFF_FFE4, 1'b0);
    send_access(32'h0000_0010, 1'b0);
    configure(3'd7, 1'b1, PF_MISS);
    send_access(32'hAAAA_AAAA, 1'b0);
    send_access(32'h5555_5555, 1'b1);
    send_access(32'hAAAA_AAAA, 1'b0);
    configure(3'd0, 1'b1, 2'd3);
    send_access(32'h8000_0000, 1'b0);
    send_access(32'h8000_0020, 1'b1);
  endtask

  // Random accesses, mostly clustered in a small region so sets fill and evict.
  task automatic test_random(input int count);
    logic [31:0] a;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 3))
        0: a = $urandom();
        1: a = $urandom_range(0, 32'h3FFF);
        default: a = 32'({3'($urandom_range(0, 7)), 14'd0}) + $urandom_range(0, 8191);
      endcase
      send_access(a, 1'($urandom_range(0, 1)));
    end
  endtask

  // Receiver stalls in a pattern: runs of ready and runs of stall.
  initial begin
    int run;
    out_tready = 1'b0;
    forever begin
      run = $urandom_range(1, 12);
      out_tready <= ($urandom_range(0, 3) != 0);
      repeat (run) @(posedge clk);
    end
  end

  // Compares each result beat with the oldest expectation.
  always @(posedge clk) begin
    lookup_result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[34:0];
      results_seen++;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_tdata);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (got.hit !== want.hit) begin
          $display("%0t: hit exp %b got %b", $time, want.hit, got.hit);
          errors++;
        end
        if (got.pf_issued !== want.pf_issued) begin
          $display("%0t: prefetch_issued exp %b got %b", $time, want.pf_issued, got.pf_issued);
          errors++;
        end
        if (got.pf_hit !== want.pf_hit) begin
          $display("%0t: prefetch_hit exp %b got %b", $time, want.pf_hit, got.pf_hit);
          errors++;
        end
        if (got.hit_count !== want.hit_count) begin
          $display("%0t: hit_count exp %0d got %0d", $time, want.hit_count, got.hit_count);
          errors++;
        end
      end
    end
  end

  // Watchdog: too many cycles with no beat moving on either side.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n)
      idle_cycles <= 0;
    else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WDOG_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    errors = 0;
    accesses_sent = 0;
    results_seen = 0;
    idle_cycles = 0;
    burst_left = 0;
    access_stamp = 0;
    demand_hits = 0;
    ways_log_reg = 0;
    store_alloc_reg = 1;
    pf_mode_reg = PF_NONE;
    for (int i = 0; i < NLINES; i++) begin
      line_ok[i] = 0;
      line_tag[i] = 0;
      line_stamp[i] = 0;
    end
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    configure(3'd0, 1'b1, PF_NONE);
    test_random(250);
    configure(3'd4, 1'b0, PF_ALWAYS);
    test_random(300);
    // Way count changes with the stores kept, read with the new layout.
    configure(3'd2, 1'b1, PF_MISS);
    test_random(300);
    configure(3'd3, 1'b0, PF_NONE);
    test_random(250);
    configure(3'd5, 1'b1, PF_ALWAYS);
    test_random(230);
    wait_drained();
    $display("Sent %0d accesses over ways 1..16, both store policies and all prefetch modes;",
             accesses_sent);
    $display("checked %0d result beats.", results_seen);
    if (errors == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end
endmodule
`default_nettype wire
